// ----- hw/rtl/touch_gesture_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// touch gesture classifier assertion macros
// shared property forms for the port checker, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define TGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tgc_pkg
// shared codes and types of the touch gesture classifier
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_DOWN   = 2'd1;
  localparam logic [1:0] CMD_MOTION = 2'd2;
  localparam logic [1:0] CMD_UP     = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SLOP_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_DEADZONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_INVERT   = 2'd3;

  localparam logic [7:0]  SLOP_RESET     = 8'd16;
  localparam logic [7:0]  DEADZONE_RESET = 8'd24;
  localparam logic [15:0] HOLD_RESET     = 16'd400;

  localparam int         COUNT_W     = 4;
  localparam logic [3:0] FCOUNT_MAX  = 4'd15;

  localparam logic [3:0] DIR_NONE = 4'd0;
  localparam logic [3:0] DIR_N    = 4'd1;
  localparam logic [3:0] DIR_NE   = 4'd2;
  localparam logic [3:0] DIR_E    = 4'd3;
  localparam logic [3:0] DIR_SE   = 4'd4;
  localparam logic [3:0] DIR_S    = 4'd5;
  localparam logic [3:0] DIR_SW   = 4'd6;
  localparam logic [3:0] DIR_W    = 4'd7;
  localparam logic [3:0] DIR_NW   = 4'd8;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_MOVE   = 3'd1,
    ACT_LPRESS = 3'd2,
    ACT_LREL   = 3'd3,
    ACT_RPRESS = 3'd4,
    ACT_RREL   = 3'd5,
    ACT_ESC    = 3'd6
  } action_e;

  // one request's outcome, queued between front and back
  typedef struct packed {
    logic [3:0] scroll_dir;
    logic       scroll_on;
    logic       two;
    action_e    act1;
    action_e    act0;
  } tgc_evt_t;

endpackage

// ----- hw/rtl/touch_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// classifies touch requests into cursor, button, escape and scroll results
// ----------------------------------------------------------------------------
// Each request passes three steps in the front classifier (operand, square,
// decide), set by the squared-distance multipliers and the gesture state
// commit; the decide step waits while the queue is full. An input register
// takes the next request while the current one is classified. A two-entry
// queue separates the classifier from the result stage, which sends one
// result per cycle while the output is not stalled, one or two results per
// request, last flagged by tlast. A request passes the input register, the
// three steps, the queue and the output register before its first result is out.
// ----------------------------------------------------------------------------
module touch_gesture_classifier #(
  parameter int COORD_WIDTH     = 12,
  parameter int FINGER_ID_WIDTH = 8,
  parameter int QUEUE_DEPTH     = 2,
  localparam int IN_DW  = ((FINGER_ID_WIDTH + 2 * COORD_WIDTH + 32 + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * COORD_WIDTH + 5 + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // finger_id, pos_x, pos_y, now_ms
  input  logic [IN_DW-1:0]               s_axis_tdata_i,
  // command
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_x, out_y, scroll_on, scroll_dir
  output logic [OUT_DW-1:0]              m_axis_tdata_o,
  // action
  output logic [2:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import tgc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FW = FINGER_ID_WIDTH;
  localparam int QW = $bits(tgc_evt_t) + 4 * CW;

  tgc_evt_t          f_evt, b_evt;
  logic [4*CW-1:0]   f_coords, b_coords;
  logic [QW-1:0]     q_out;
  logic              q_push, q_pop, q_full, q_empty;

  tgc_front #(
    .COORD_WIDTH     (CW),
    .FINGER_ID_WIDTH (FW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .command_i   (s_axis_tuser_i),
    .finger_id_i (s_axis_tdata_i[FW-1:0]),
    .pos_x_i     (s_axis_tdata_i[FW +: CW]),
    .pos_y_i     (s_axis_tdata_i[FW+CW +: CW]),
    .now_ms_i    (s_axis_tdata_i[FW+2*CW +: 32]),
    .push_o      (q_push),
    .full_i      (q_full),
    .evt_o       (f_evt),
    .coords_o    (f_coords)
  );

  tgc_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_coords, f_evt}),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_evt    = q_out[$bits(tgc_evt_t)-1:0];
  assign b_coords = q_out[QW-1:$bits(tgc_evt_t)];

  tgc_back #(
    .COORD_WIDTH (CW),
    .OUT_DW      (OUT_DW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (b_evt),
    .coords_i  (b_coords),
    .empty_i   (q_empty),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

// ----- hw/rtl/tgc_fifo.sv -----
// ----------------------------------------------------------------------------
// tgc_fifo
// small show-ahead queue of classified requests
// ----------------------------------------------------------------------------
module tgc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/tgc_front.sv -----
// ----------------------------------------------------------------------------
// tgc_front
// input register, configuration registers and three-step gesture classifier
// ----------------------------------------------------------------------------
module tgc_front #(
  parameter int COORD_WIDTH     = 12,
  parameter int FINGER_ID_WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [1:0]                   command_i,
  input  logic [FINGER_ID_WIDTH-1:0]   finger_id_i,
  input  logic [COORD_WIDTH-1:0]       pos_x_i,
  input  logic [COORD_WIDTH-1:0]       pos_y_i,
  input  logic [31:0]                  now_ms_i,
  output logic                         push_o,
  input  logic                         full_i,
  output tgc_pkg::tgc_evt_t            evt_o,
  output logic [4*COORD_WIDTH-1:0]     coords_o
);
  import tgc_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int FW  = FINGER_ID_WIDTH;
  localparam int SQW = 2 * CW;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_PEND = 3'd1;
  localparam logic [2:0] MODE_DRAG = 3'd2;
  localparam logic [2:0] MODE_PAN  = 3'd3;
  localparam logic [2:0] MODE_TWO  = 3'd4;

  // configuration
  logic [7:0]  slop_q, dead_q;
  logic [15:0] hold_time_q;
  logic        invert_q;

  // input register
  logic          ib_valid_q;
  logic [1:0]    ib_cmd_q;
  logic [FW-1:0] ib_fid_q;
  logic [CW-1:0] ib_x_q, ib_y_q;
  logic [31:0]   ib_now_q;
  logic          take;

  // work registers
  logic [1:0]    step_q, step_d;
  logic [1:0]    cmd_q;
  logic [FW-1:0] fid_q;
  logic [CW-1:0] x_q, y_q;
  logic [31:0]   now_q;
  logic          fid_match_q, held_q;
  logic [CW:0]   dx_q, dy_q;
  logic [CW-1:0] ax_q, ay_q;
  logic [15:0]   slop_sq_q, dead_sq_q;
  logic [SQW-1:0] sqx_q, sqy_q;

  // gesture state
  logic [2:0]         mode_q, mode_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_inc, cnt_dec;
  logic [FW-1:0]      tracked_q, tracked_d;
  logic [CW-1:0]      ox_q, ox_d, oy_q, oy_d;
  logic [31:0]        hold_start_q, hold_start_d;
  logic               pan_eng_q, pan_eng_d, esc_sent_q, esc_sent_d;
  logic               scroll_q, scroll_d;
  logic [3:0]         dir_q, dir_d;

  logic [CW:0]   dx_c, dy_c;
  logic [31:0]   elapsed;
  logic [SQW:0]  msq;
  logic          slop_hit, dead_hit, commit;
  logic          x_pos, y_pos;
  logic [CW-1:0] cx0, cy0, cx1, cy1;
  tgc_evt_t      evt;

  function automatic logic [3:0] dir_of(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                        logic px, logic py);
    logic [3:0] d;
    if ({1'b0, ax} > {ay, 1'b0}) begin
      d = px ? DIR_E : DIR_W;
    end else if ({1'b0, ay} > {ax, 1'b0}) begin
      d = py ? DIR_S : DIR_N;
    end else if (px) begin
      d = py ? DIR_SE : DIR_NE;
    end else begin
      d = py ? DIR_SW : DIR_NW;
    end
    return d;
  endfunction

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slop_q      <= SLOP_RESET;
      dead_q      <= DEADZONE_RESET;
      hold_time_q <= HOLD_RESET;
      invert_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOP_RADIUS:  slop_q      <= cfg_wdata_i[7:0];
        REG_PAN_DEADZONE: dead_q      <= cfg_wdata_i[7:0];
        REG_HOLD_TIME:    hold_time_q <= cfg_wdata_i[15:0];
        REG_PAN_INVERT:   invert_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register accepts the next request while one is in flight
  assign take    = ib_valid_q && (step_q == ST_LOAD);
  assign ready_o = !ib_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ib_valid_q <= 1'b0;
    end else if (ready_o) begin
      ib_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ib_cmd_q <= command_i;
      ib_fid_q <= finger_id_i;
      ib_x_q   <= pos_x_i;
      ib_y_q   <= pos_y_i;
      ib_now_q <= now_ms_i;
    end
  end

  // operand step
  assign dx_c    = {1'b0, ib_x_q} - {1'b0, ox_q};
  assign dy_c    = {1'b0, ib_y_q} - {1'b0, oy_q};
  assign elapsed = ib_now_q - hold_start_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q       <= ib_cmd_q;
      fid_q       <= ib_fid_q;
      x_q         <= ib_x_q;
      y_q         <= ib_y_q;
      now_q       <= ib_now_q;
      fid_match_q <= (ib_fid_q == tracked_q);
      held_q      <= (elapsed >= {16'd0, hold_time_q});
      dx_q        <= dx_c;
      dy_q        <= dy_c;
      ax_q        <= dx_c[CW] ? CW'(-dx_c) : dx_c[CW-1:0];
      ay_q        <= dy_c[CW] ? CW'(-dy_c) : dy_c[CW-1:0];
      slop_sq_q   <= {8'd0, slop_q} * {8'd0, slop_q};
      dead_sq_q   <= {8'd0, dead_q} * {8'd0, dead_q};
    end
    if (step_q == ST_SQ) begin
      sqx_q <= SQW'(ax_q) * SQW'(ax_q);
      sqy_q <= SQW'(ay_q) * SQW'(ay_q);
    end
  end

  always_comb begin
    step_d = step_q;
    case (step_q)
      ST_LOAD: if (take) step_d = ST_SQ;
      ST_SQ:   step_d = ST_DEC;
      ST_DEC:  if (!full_i) step_d = ST_LOAD;
      default: step_d = ST_LOAD;
    endcase
  end

  // decision step
  assign msq      = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign slop_hit = msq > (SQW + 1)'(slop_sq_q);
  assign dead_hit = msq > (SQW + 1)'(dead_sq_q);
  assign x_pos    = invert_q ? dx_q[CW] : (!dx_q[CW] && (dx_q != '0));
  assign y_pos    = invert_q ? dy_q[CW] : (!dy_q[CW] && (dy_q != '0));
  assign cnt_inc  = (cnt_q == FCOUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
  assign cnt_dec  = (cnt_q == '0) ? cnt_q : cnt_q - COUNT_W'(1);

  always_comb begin
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    tracked_d    = tracked_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    hold_start_d = hold_start_q;
    pan_eng_d    = pan_eng_q;
    esc_sent_d   = esc_sent_q;
    scroll_d     = scroll_q;
    dir_d        = dir_q;
    evt.act0     = ACT_NONE;
    evt.act1     = ACT_NONE;
    evt.two      = 1'b0;
    cx0          = '0;
    cy0          = '0;
    cx1          = '0;
    cy1          = '0;
    case (cmd_q)
      CMD_TICK: begin
        if (mode_q == MODE_PEND && held_q) mode_d = MODE_PAN;
      end
      CMD_DOWN: begin
        cnt_d = cnt_inc;
        if (mode_q == MODE_PEND && cnt_inc == COUNT_W'(2)) begin
          mode_d     = MODE_TWO;
          esc_sent_d = 1'b0;
        end else if (mode_q == MODE_IDLE) begin
          tracked_d    = fid_q;
          ox_d         = x_q;
          oy_d         = y_q;
          hold_start_d = now_q;
          mode_d       = MODE_PEND;
          pan_eng_d    = 1'b0;
          evt.act0     = ACT_MOVE;
          cx0          = x_q;
          cy0          = y_q;
        end
      end
      default: begin
        if (mode_q == MODE_TWO) begin
          if (cmd_q == CMD_UP) begin
            cnt_d = cnt_dec;
            if (!esc_sent_q) begin
              evt.act0   = ACT_ESC;
              esc_sent_d = 1'b1;
            end
            if (cnt_dec == '0) begin
              mode_d    = MODE_IDLE;
              tracked_d = '0;
            end
          end
        end else if (!fid_match_q) begin
          if (cmd_q == CMD_UP) cnt_d = cnt_dec;
        end else if (cmd_q == CMD_MOTION) begin
          case (mode_q)
            MODE_PEND: begin
              if (slop_hit) begin
                mode_d   = MODE_DRAG;
                evt.act0 = ACT_LPRESS;
                evt.act1 = ACT_MOVE;
                evt.two  = 1'b1;
                cx0      = ox_q;
                cy0      = oy_q;
                cx1      = x_q;
                cy1      = y_q;
              end
            end
            MODE_DRAG: begin
              evt.act0 = ACT_MOVE;
              cx0      = x_q;
              cy0      = y_q;
            end
            MODE_PAN: begin
              if (dead_hit) begin
                scroll_d  = 1'b1;
                pan_eng_d = 1'b1;
                dir_d     = dir_of(ax_q, ay_q, x_pos, y_pos);
              end else begin
                scroll_d = 1'b0;
              end
            end
            default: ;
          endcase
        end else begin
          case (mode_q)
            MODE_PEND: begin
              evt.act0 = ACT_LPRESS;
              evt.act1 = ACT_LREL;
              evt.two  = 1'b1;
              cx0      = x_q;
              cy0      = y_q;
              cx1      = x_q;
              cy1      = y_q;
            end
            MODE_DRAG: begin
              evt.act0 = ACT_LREL;
              cx0      = x_q;
              cy0      = y_q;
            end
            MODE_PAN: begin
              scroll_d = 1'b0;
              dir_d    = DIR_NONE;
              if (!pan_eng_q) begin
                evt.act0 = ACT_RPRESS;
                evt.act1 = ACT_RREL;
                evt.two  = 1'b1;
                cx0      = ox_q;
                cy0      = oy_q;
                cx1      = ox_q;
                cy1      = oy_q;
              end
            end
            default: ;
          endcase
          cnt_d     = cnt_dec;
          mode_d    = MODE_IDLE;
          tracked_d = '0;
        end
      end
    endcase
    evt.scroll_on  = scroll_d;
    evt.scroll_dir = dir_d;
  end

  assign commit   = (step_q == ST_DEC) && !full_i;
  assign push_o   = commit;
  assign evt_o    = evt;
  assign coords_o = {cy1, cx1, cy0, cx0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= ST_LOAD;
      mode_q       <= MODE_IDLE;
      cnt_q        <= '0;
      tracked_q    <= '0;
      ox_q         <= '0;
      oy_q         <= '0;
      hold_start_q <= '0;
      pan_eng_q    <= 1'b0;
      esc_sent_q   <= 1'b0;
      scroll_q     <= 1'b0;
      dir_q        <= DIR_NONE;
    end else begin
      step_q <= step_d;
      if (commit) begin
        mode_q       <= mode_d;
        cnt_q        <= cnt_d;
        tracked_q    <= tracked_d;
        ox_q         <= ox_d;
        oy_q         <= oy_d;
        hold_start_q <= hold_start_d;
        pan_eng_q    <= pan_eng_d;
        esc_sent_q   <= esc_sent_d;
        scroll_q     <= scroll_d;
        dir_q        <= dir_d;
      end
    end
  end

endmodule

// ----- hw/rtl/tgc_back.sv -----
// ----------------------------------------------------------------------------
// tgc_back
// expands queued outcomes into result items behind an output register
// ----------------------------------------------------------------------------
module tgc_back #(
  parameter int COORD_WIDTH = 12,
  parameter int OUT_DW      = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tgc_pkg::tgc_evt_t        evt_i,
  input  logic [4*COORD_WIDTH-1:0] coords_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [OUT_DW-1:0]        m_data_o,
  output logic [2:0]               m_user_o,
  output logic                     m_last_o
);
  import tgc_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic              valid_q, valid_d;
  logic              idx_q, idx_d;
  logic [OUT_DW-1:0] data_q;
  logic [2:0]        user_q;
  logic              last_q;
  logic              load, fetch, is_last;
  logic [CW-1:0]     sel_x, sel_y;
  action_e           sel_act;

  assign load    = !valid_q || m_ready_i;
  assign fetch   = load && !empty_i;
  assign is_last = idx_q || !evt_i.two;
  assign sel_act = idx_q ? evt_i.act1 : evt_i.act0;
  assign sel_x   = idx_q ? coords_i[2*CW +: CW] : coords_i[0 +: CW];
  assign sel_y   = idx_q ? coords_i[3*CW +: CW] : coords_i[CW +: CW];
  assign pop_o   = fetch && is_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) valid_d = !empty_i;
    if (fetch) idx_d = !is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      data_q <= OUT_DW'({evt_i.scroll_dir, evt_i.scroll_on, sel_y, sel_x});
      user_q <= sel_act;
      last_q <= is_last;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;
  assign m_last_o  = last_q;

endmodule

// ----- hw/rtl/tgc_checker.sv -----
// ----------------------------------------------------------------------------
// tgc_checker
// port-level checks on the result stream of the gesture classifier
// ----------------------------------------------------------------------------
`include "touch_gesture_classifier_assert.svh"

module tgc_checker #(
  parameter int COORD_WIDTH = 12,
  localparam int OUT_DW = ((2 * COORD_WIDTH + 5 + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [OUT_DW-1:0] m_axis_tdata_o,
  input logic [2:0]        m_axis_tuser_o,
  input logic              m_axis_tlast_o
);
  import tgc_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic       stalled, no_coord, first_of_two, scroll_on;
  logic [3:0] scroll_dir;

  assign stalled      = m_axis_tvalid_o && !m_axis_tready_i;
  assign no_coord     = m_axis_tvalid_o &&
                        (m_axis_tuser_o == ACT_NONE || m_axis_tuser_o == ACT_ESC);
  assign first_of_two = m_axis_tvalid_o && !m_axis_tlast_o;
  assign scroll_on    = m_axis_tdata_o[2*CW];
  assign scroll_dir   = m_axis_tdata_o[2*CW+1 +: 4];

  `TGC_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result dropped while stalled")
  `TGC_ASSERT_NOW(a_zero_coord, no_coord, m_axis_tdata_o[2*CW-1:0] == '0, "coordinates on a result without position")
  `TGC_ASSERT_NOW(a_pair_press, first_of_two, m_axis_tuser_o == ACT_LPRESS || m_axis_tuser_o == ACT_RPRESS, "two-result request not led by a press")
  `TGC_ASSERT_NOW(a_scroll_dir, m_axis_tvalid_o && scroll_on, scroll_dir != DIR_NONE, "scrolling without a direction")

endmodule

bind touch_gesture_classifier tgc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);
